// ===== rtl/biba_pkg.sv =====
// ----------------------------------------------------------------------------
// biba_pkg
// Shared types and constants of the bitmap inode/block allocator.
// ----------------------------------------------------------------------------
package biba_pkg;

  localparam int MAP_BITS_DEF = 8192;
  localparam int NUM_W        = 14;
  localparam int WORD_W       = 32;
  localparam int BIT_W        = 5;
  localparam int CMD_W        = 2;
  localparam int STAT_W       = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 14;
  localparam int TDATA_W      = 16;

  localparam logic [NUM_W-1:0] COUNT_RST = NUM_W'(8192);

  localparam logic [CFG_IDX_W-1:0] REG_INODE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC_INODE = 2'd0,
    CMD_FREE_INODE  = 2'd1,
    CMD_ALLOC_BLOCK = 2'd2,
    CMD_FREE_BLOCK  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic             found;
    logic             last;
    logic [BIT_W-1:0] pos;
  } scan_res_t;

  // Position of the lowest set bit; binary search over halves.
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] v;
    logic [BIT_W-1:0]  pos;
    v   = x;
    pos = '0;
    for (int i = BIT_W - 1; i >= 0; i--) begin
      if ((v & ((WORD_W'(1) << (1 << i)) - WORD_W'(1))) == '0) begin
        v      = v >> (1 << i);
        pos[i] = 1'b1;
      end
    end
    return pos;
  endfunction

endpackage

// ===== rtl/bitmap_inode_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_inode_block_allocator_unit
// First-fit allocator over an inode bitmap and a block bitmap.
// ----------------------------------------------------------------------------
// Sequence: a free reads its map word and writes it back with the bit
//   cleared; a range error goes straight to the result; an allocation scans
//   up to ceil(limit/32) 32-bit words, 256 at the default map size.
// Throughput: one command at a time; the word scan reads one memory word
//   per cycle through the single read port.
// Reset: synchronous; a clearing pass zeroes every word of both maps,
//   during which no command is accepted.
// ----------------------------------------------------------------------------
module bitmap_inode_block_allocator_unit import biba_pkg::*; #(
  parameter int MAP_BITS = MAP_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // commands
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,   // [1:0] cmd, [15:2] number
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata   // [13:0] allocated, [15:14] status
);

  localparam int WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LIM_W = $clog2(MAP_BITS + 1);
  localparam int CW    = (LIM_W > NUM_W) ? LIM_W : NUM_W;

  fsm_t state_r, state_nxt;

  logic [NUM_W-1:0]  inode_count_r;
  logic [NUM_W-1:0]  block_count_r;
  logic [AW-1:0]     clr_w_r;
  logic [AW-1:0]     rd_w_r;
  logic [AW-1:0]     ev_w_r;
  logic              sel_r;
  logic [AW-1:0]     fw_r;
  logic [BIT_W-1:0]  fbit_r;
  logic [NUM_W-1:0]  res_alloc_r;
  status_t           res_stat_r;
  logic              out_valid_r;
  logic [NUM_W-1:0]  out_alloc_r;
  status_t           out_stat_r;

  cmd_t              in_cmd;
  logic [NUM_W-1:0]  in_number;
  logic [CW-1:0]     lim_inode;
  logic [CW-1:0]     lim_block;
  logic [CW-1:0]     lim_sel;
  logic              in_free;
  logic              in_bad;
  logic [CW-1:0]     free_idx;
  logic              accept;
  logic              out_load;

  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic              we_inode;
  logic              we_block;
  logic [WORD_W-1:0] rdata_inode;
  logic [WORD_W-1:0] rdata_block;
  logic [WORD_W-1:0] rdata;
  scan_res_t         scan;
  logic [CW:0]       found_idx;

  assign in_cmd    = cmd_t'(in_tdata[CMD_W-1:0]);
  assign in_number = in_tdata[CMD_W +: NUM_W];

  assign lim_inode = (CW'(inode_count_r) > CW'(MAP_BITS)) ? CW'(MAP_BITS)
                                                          : CW'(inode_count_r);
  assign lim_block = (CW'(block_count_r) > CW'(MAP_BITS)) ? CW'(MAP_BITS)
                                                          : CW'(block_count_r);
  assign lim_sel   = sel_r ? lim_block : lim_inode;

  assign accept   = in_tvalid && in_tready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    in_free  = 1'b0;
    in_bad   = 1'b0;
    free_idx = CW'(in_number);
    unique case (in_cmd)
      CMD_FREE_INODE: begin
        in_free  = 1'b1;
        in_bad   = (in_number == '0) || (CW'(in_number) > lim_inode);
        free_idx = CW'(in_number) - CW'(1);
      end
      CMD_FREE_BLOCK: begin
        in_free  = 1'b1;
        in_bad   = CW'(in_number) >= lim_block;
      end
      default: begin
        in_free  = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_w_r == AW'(WORDS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_tvalid) begin
          priority if (!in_free) state_nxt = S_SCAN;
          else if (in_bad)       state_nxt = S_DONE;
          else                   state_nxt = S_FREE;
        end
      end
      S_SCAN:  if (scan.found || scan.last) state_nxt = S_DONE;
      S_FREE:  state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    in_tready = 1'b0;
    raddr     = '0;
    waddr     = clr_w_r;
    wdata     = '0;
    we_inode  = 1'b0;
    we_block  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        we_inode = 1'b1;
        we_block = 1'b1;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        raddr     = in_free ? free_idx[AW+BIT_W-1:BIT_W] : '0;
      end
      S_SCAN: begin
        raddr    = rd_w_r;
        waddr    = ev_w_r;
        wdata    = rdata | (WORD_W'(1) << scan.pos);
        we_inode = scan.found && !sel_r;
        we_block = scan.found && sel_r;
      end
      S_FREE: begin
        waddr    = fw_r;
        wdata    = rdata & ~(WORD_W'(1) << fbit_r);
        we_inode = !sel_r;
        we_block = sel_r;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  biba_bitmap_mem #(.DEPTH(WORDS), .AW(AW)) u_inode_mem (
    .clk   (clk),
    .we    (we_inode),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_inode)
  );

  biba_bitmap_mem #(.DEPTH(WORDS), .AW(AW)) u_block_mem (
    .clk   (clk),
    .we    (we_block),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_block)
  );

  assign rdata = sel_r ? rdata_block : rdata_inode;

  biba_word_scan #(.AW(AW), .CW(CW)) u_scan (
    .word     (rdata),
    .word_idx (ev_w_r),
    .lim      (lim_sel),
    .res      (scan)
  );

  assign found_idx = (CW + 1)'({ev_w_r, scan.pos}) + (CW + 1)'(!sel_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_w_r       <= '0;
      inode_count_r <= COUNT_RST;
      block_count_r <= COUNT_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_w_r <= clr_w_r + AW'(1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INODE_COUNT: inode_count_r <= cfg_data;
          REG_BLOCK_COUNT: block_count_r <= cfg_data;
          default:         inode_count_r <= inode_count_r;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sel_r       <= in_cmd[1];
      ev_w_r      <= '0;
      rd_w_r      <= AW'(1);
      fw_r        <= free_idx[AW+BIT_W-1:BIT_W];
      fbit_r      <= free_idx[BIT_W-1:0];
      res_alloc_r <= '0;
      res_stat_r  <= (in_free && in_bad) ? STAT_RANGE : STAT_DONE;
    end
    if (state_r == S_SCAN) begin
      ev_w_r <= rd_w_r;
      rd_w_r <= rd_w_r + AW'(1);
      if (scan.found) begin
        res_alloc_r <= found_idx[NUM_W-1:0];
        res_stat_r  <= STAT_DONE;
      end else if (scan.last) begin
        res_alloc_r <= '0;
        res_stat_r  <= STAT_FULL;
      end
    end
    if (out_load) begin
      out_alloc_r <= res_alloc_r;
      out_stat_r  <= res_stat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_stat_r, out_alloc_r};

endmodule

// ===== rtl/biba_bitmap_mem.sv =====
// ----------------------------------------------------------------------------
// biba_bitmap_mem
// One bitmap store: single write port, one registered read port.
// ----------------------------------------------------------------------------
module biba_bitmap_mem import biba_pkg::*; #(
  parameter int DEPTH = MAP_BITS_DEF / WORD_W,
  parameter int AW    = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/biba_word_scan.sv =====
// ----------------------------------------------------------------------------
// biba_word_scan
// Lowest clear bit of one bitmap word below the map limit.
// ----------------------------------------------------------------------------
module biba_word_scan import biba_pkg::*; #(
  parameter int AW = 8,
  parameter int CW = 14
) (
  input  logic [WORD_W-1:0] word,
  input  logic [AW-1:0]     word_idx,
  input  logic [CW-1:0]     lim,
  output scan_res_t         res
);

  localparam int EW = CW + 1;

  logic [EW-1:0]     base;
  logic [EW-1:0]     rem;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] cand;

  always_comb begin
    base = EW'({word_idx, {BIT_W{1'b0}}});
    rem  = EW'(lim) - base;
    if (rem >= EW'(WORD_W)) begin
      mask = '1;
    end else begin
      mask = (WORD_W'(1) << rem[BIT_W-1:0]) - WORD_W'(1);
    end
    cand      = ~word & mask;
    res.found = (cand != '0);
    res.last  = (base + EW'(WORD_W)) >= EW'(lim);
    res.pos   = lowest_set(cand);
  end

endmodule
